// ===== src/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types, register codes and address checks of the DMA channel core.
// ----------------------------------------------------------------------------
package dmac_pkg;

  // number of implemented channels (address bits 6-4 pick one of eight)
  localparam int unsigned DMAC_CHANNELS = 8;
  localparam int unsigned CH_W          = 3;
  localparam int unsigned SPARE_SLOTS   = 5;

  // register window: reg id is address & mask, block base in the upper bits
  localparam logic [15:0] DMAC_REG_MASK = 16'hFF8F;
  localparam logic [15:0] DMAC_REG_BASE = 16'h4300;

  // A-bus regions that may not be the other side of a transfer
  localparam logic [23:0] A_BBUS_MASK  = 24'h40FF00;
  localparam logic [23:0] A_BBUS_BASE  = 24'h002100;
  localparam logic [23:0] A_OLDIO_MASK = 24'h40FE00;
  localparam logic [23:0] A_OLDIO_BASE = 24'h004000;
  localparam logic [23:0] A_CPUIO_MASK = 24'h40FFE0;
  localparam logic [23:0] A_CPUIO_BASE = 24'h004200;
  localparam logic [23:0] A_DMAIO_MASK = 24'h40FF80;
  localparam logic [23:0] A_DMAIO_BASE = 24'h004300;

  // work RAM detection for the data port check
  localparam logic [23:0] WRAM_BANK_MASK = 24'hFE0000;
  localparam logic [23:0] WRAM_BANK_BASE = 24'h7E0000;
  localparam logic [23:0] WRAM_LOW_MASK  = 24'h40E000;
  localparam logic [7:0]  WRAM_DATA_PORT = 8'h80;

  // control byte fields
  localparam int unsigned CTL_DIR     = 7;
  localparam int unsigned CTL_REVERSE = 4;
  localparam int unsigned CTL_FIXED   = 3;

  // register codes (low address nibble)
  localparam logic [3:0] REG_CONTROL  = 4'h0;
  localparam logic [3:0] REG_BBASE    = 4'h1;
  localparam logic [3:0] REG_SRC_LO   = 4'h2;
  localparam logic [3:0] REG_SRC_HI   = 4'h3;
  localparam logic [3:0] REG_SRC_BANK = 4'h4;
  localparam logic [3:0] REG_CNT_LO   = 4'h5;
  localparam logic [3:0] REG_CNT_HI   = 4'h6;
  localparam logic [3:0] REG_IND_BANK = 4'h7;
  localparam logic [3:0] REG_TBL_LO   = 4'h8;
  localparam logic [3:0] REG_TBL_HI   = 4'h9;
  localparam logic [3:0] REG_LINE_CNT = 4'hA;
  localparam logic [3:0] REG_UNUSED   = 4'hB;
  localparam logic [3:0] REG_UNUSED_M = 4'hF;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_ENABLE = 2'd2,
    ACT_STEP   = 2'd3
  } action_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_XFER = 1'b1
  } kind_e;

  // request from the sequencer into the channel register file
  typedef struct packed {
    logic            wr;
    logic            step;
    logic            sel_ok;
    logic [CH_W-1:0] ch;
    logic [3:0]      rsel;
    logic [7:0]      data;
    logic [CH_W-1:0] step_ch;
  } rf_req_t;

  // registers of the channel chosen for a transfer step
  typedef struct packed {
    logic [7:0]  ctl;
    logic [7:0]  base;
    logic [15:0] offset;
    logic [7:0]  bank;
    logic [15:0] count;
  } rf_view_t;

  // one result beat
  typedef struct packed {
    logic            kind;
    logic [7:0]      read_data;
    logic [23:0]     a_address;
    logic [7:0]      b_register;
    logic            b_to_a;
    logic            a_access_allowed;
    logic            wram_pair_allowed;
    logic [CH_W-1:0] channel;
    logic            channel_done;
  } rsp_t;

  // B register offset for the transfer unit pattern
  function automatic logic [1:0] pat_offset(logic [2:0] mode, logic [1:0] pos);
    logic [1:0] off;
    off = 2'd0;
    case (mode)
      3'd1, 3'd5: off = {1'b0, pos[0]};
      3'd3, 3'd7: off = {1'b0, pos[1]};
      3'd4:       off = pos;
      default:    off = 2'd0;
    endcase
    return off;
  endfunction

  function automatic logic a_ok(logic [23:0] a);
    return !(((a & A_BBUS_MASK) == A_BBUS_BASE) ||
             ((a & A_OLDIO_MASK) == A_OLDIO_BASE) ||
             ((a & A_CPUIO_MASK) == A_CPUIO_BASE) ||
             ((a & A_DMAIO_MASK) == A_DMAIO_BASE));
  endfunction

  function automatic logic wram_ok(logic [7:0] b, logic [23:0] a);
    logic is_wram;
    is_wram = ((a & WRAM_BANK_MASK) == WRAM_BANK_BASE) || ((a & WRAM_LOW_MASK) == 24'h0);
    return (b != WRAM_DATA_PORT) || !is_wram;
  endfunction

  // spare byte slot of a register code (only valid for spare codes)
  function automatic logic [2:0] spare_slot(logic [3:0] rsel);
    logic [2:0] s;
    s = 3'd0;
    case (rsel)
      REG_IND_BANK: s = 3'd0;
      REG_TBL_LO:   s = 3'd1;
      REG_TBL_HI:   s = 3'd2;
      REG_LINE_CNT: s = 3'd3;
      default:      s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

// ===== src/dmac_if.sv =====
// ----------------------------------------------------------------------------
// dmac_in_if / dmac_out_if
// Valid/ready channels for CPU requests and result beats of the DMA core.
// ----------------------------------------------------------------------------
interface dmac_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  open_bus_value;

  modport source (output valid, action, address, write_data, open_bus_value,
                  input ready);
  modport sink (input valid, action, address, write_data, open_bus_value,
                output ready);
endinterface

interface dmac_out_if ();
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  read_data;
  logic [23:0] a_address;
  logic [7:0]  b_register;
  logic        b_to_a;
  logic        a_access_allowed;
  logic        wram_pair_allowed;
  logic [2:0]  channel;
  logic        channel_done;

  modport source (output valid, kind, read_data, a_address, b_register, b_to_a,
                  a_access_allowed, wram_pair_allowed, channel, channel_done,
                  input ready);
  modport sink (input valid, kind, read_data, a_address, b_register, b_to_a,
                a_access_allowed, wram_pair_allowed, channel, channel_done,
                output ready);
endinterface

// ===== src/dmac_regfile.sv =====
// ----------------------------------------------------------------------------
// dmac_regfile
// Per-channel register file: CPU byte reads and writes, and the source
// address and byte count update of a transfer step.
// ----------------------------------------------------------------------------
module dmac_regfile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmac_pkg::rf_req_t  req_i,
  output logic [7:0]         rd_data_o,
  output logic               rd_hit_o,
  output dmac_pkg::rf_view_t view_o
);

  dmac_pkg::rf_view_t chan_q  [dmac_pkg::DMAC_CHANNELS];
  // spare bytes of one channel kept together, one word per channel
  logic [dmac_pkg::SPARE_SLOTS-1:0][7:0] spare_q [dmac_pkg::DMAC_CHANNELS];

  dmac_pkg::rf_view_t rd_ch;
  dmac_pkg::rf_view_t st_ch;
  logic [2:0]         slot;

  assign slot  = dmac_pkg::spare_slot(req_i.rsel);
  assign rd_ch = chan_q[req_i.ch];
  assign st_ch = chan_q[req_i.step_ch];

  // view of the stepping channel
  assign view_o = st_ch;

  // register read decode
  always_comb begin
    rd_data_o = 8'h00;
    rd_hit_o  = req_i.sel_ok;
    unique case (req_i.rsel) inside
      dmac_pkg::REG_CONTROL:  rd_data_o = rd_ch.ctl;
      dmac_pkg::REG_BBASE:    rd_data_o = rd_ch.base;
      dmac_pkg::REG_SRC_LO:   rd_data_o = rd_ch.offset[7:0];
      dmac_pkg::REG_SRC_HI:   rd_data_o = rd_ch.offset[15:8];
      dmac_pkg::REG_SRC_BANK: rd_data_o = rd_ch.bank;
      dmac_pkg::REG_CNT_LO:   rd_data_o = rd_ch.count[7:0];
      dmac_pkg::REG_CNT_HI:   rd_data_o = rd_ch.count[15:8];
      dmac_pkg::REG_IND_BANK, dmac_pkg::REG_TBL_LO, dmac_pkg::REG_TBL_HI,
      dmac_pkg::REG_LINE_CNT, dmac_pkg::REG_UNUSED, dmac_pkg::REG_UNUSED_M:
        rd_data_o = spare_q[req_i.ch][slot];
      default: rd_hit_o = 1'b0;
    endcase
  end

  // register writes and step updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < dmac_pkg::DMAC_CHANNELS; c++) begin
        chan_q[c]  <= '0;
        spare_q[c] <= '0;
      end
    end else if (req_i.step) begin
      if (!st_ch.ctl[dmac_pkg::CTL_FIXED]) begin
        if (st_ch.ctl[dmac_pkg::CTL_REVERSE]) begin
          chan_q[req_i.step_ch].offset <= st_ch.offset - 16'd1;
        end else begin
          chan_q[req_i.step_ch].offset <= st_ch.offset + 16'd1;
        end
      end
      chan_q[req_i.step_ch].count <= st_ch.count - 16'd1;
    end else if (req_i.wr && req_i.sel_ok) begin
      unique case (req_i.rsel) inside
        dmac_pkg::REG_CONTROL:  chan_q[req_i.ch].ctl          <= req_i.data;
        dmac_pkg::REG_BBASE:    chan_q[req_i.ch].base         <= req_i.data;
        dmac_pkg::REG_SRC_LO:   chan_q[req_i.ch].offset[7:0]  <= req_i.data;
        dmac_pkg::REG_SRC_HI:   chan_q[req_i.ch].offset[15:8] <= req_i.data;
        dmac_pkg::REG_SRC_BANK: chan_q[req_i.ch].bank         <= req_i.data;
        dmac_pkg::REG_CNT_LO:   chan_q[req_i.ch].count[7:0]   <= req_i.data;
        dmac_pkg::REG_CNT_HI:   chan_q[req_i.ch].count[15:8]  <= req_i.data;
        dmac_pkg::REG_IND_BANK, dmac_pkg::REG_TBL_LO, dmac_pkg::REG_TBL_HI,
        dmac_pkg::REG_LINE_CNT, dmac_pkg::REG_UNUSED, dmac_pkg::REG_UNUSED_M:
          spare_q[req_i.ch][slot] <= req_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dma_channel_register_and_transfer_core.sv =====
// ----------------------------------------------------------------------------
// dma_channel_register_and_transfer_core
// Eight-channel general DMA: register file access and byte transfer commands.
//
//   port    dir  beat contents
//   req_i   in   action, address, write_data, open_bus_value
//   rsp_o   out  kind, read_data, transfer command fields, channel, done
//
// A request beat lands in the input register and is executed from there
// into the result register: one beat per cycle sustained while no read or
// step waits on a stalled result. Reads and steps with a running channel
// give one result beat, writes, enable writes and idle steps give none. A
// stalled result holds a read or a step with a running channel in the
// execute stage; writes pass, and the input register takes a beat whenever
// the execute stage drains. Reset clears the channel registers, run flags
// and valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module dma_channel_register_and_transfer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  dmac_in_if.sink   req_i,
  dmac_out_if.source rsp_o
);

  localparam int unsigned CH = dmac_pkg::DMAC_CHANNELS;

  // input register
  logic        s_valid_q;
  logic [1:0]  s_action_q;
  logic [15:0] s_addr_q;
  logic [7:0]  s_wdata_q;
  logic [7:0]  s_obus_q;

  // run state
  logic [CH-1:0] run_q, run_d;
  logic [1:0]    pos_q, pos_d;

  // result register
  logic           out_valid_q;
  dmac_pkg::rsp_t out_q;

  dmac_pkg::rf_req_t  rf_req;
  dmac_pkg::rf_view_t view;
  logic [7:0]         rd_data;
  logic               rd_hit;

  logic [15:0]                 masked;
  logic [dmac_pkg::CH_W-1:0]   ch;
  logic                        sel_ok;
  logic                        is_read, is_write, is_enable, is_step;
  logic                        found;
  logic [dmac_pkg::CH_W-1:0]   step_ch;
  logic                        emit, out_free, adv;
  logic [23:0]                 a_addr;
  logic [7:0]                  b_reg;
  logic                        done;
  dmac_pkg::rsp_t              rsp_d;

  // decode of the held request
  assign masked    = s_addr_q & dmac_pkg::DMAC_REG_MASK;
  assign ch        = s_addr_q[6:4];
  assign sel_ok    = (masked[15:4] == dmac_pkg::DMAC_REG_BASE[15:4]) &&
                     ({1'b0, ch} < 4'(CH));
  assign is_read   = s_action_q == dmac_pkg::ACT_READ;
  assign is_write  = s_action_q == dmac_pkg::ACT_WRITE;
  assign is_enable = s_action_q == dmac_pkg::ACT_ENABLE;
  assign is_step   = s_action_q == dmac_pkg::ACT_STEP;

  // lowest running channel
  always_comb begin
    step_ch = '0;
    for (int c = CH - 1; c >= 0; c--) begin
      if (run_q[c]) step_ch = dmac_pkg::CH_W'(c);
    end
  end
  assign found = |run_q;

  // handshake and stage advance
  assign emit        = is_read || (is_step && found);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign adv         = s_valid_q && (!emit || out_free);
  assign req_i.ready = !s_valid_q || adv;

  assign rf_req = '{
    wr:      adv && is_write,
    step:    adv && is_step && found,
    sel_ok:  sel_ok,
    ch:      ch,
    rsel:    s_addr_q[3:0],
    data:    s_wdata_q,
    step_ch: step_ch
  };

  dmac_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rf_req),
    .rd_data_o (rd_data),
    .rd_hit_o  (rd_hit),
    .view_o    (view)
  );

  // transfer command
  assign a_addr = {view.bank, view.offset};
  assign b_reg  = view.base + {6'd0, dmac_pkg::pat_offset(view.ctl[2:0], pos_q)};
  assign done   = view.count == 16'd1;

  always_comb begin
    rsp_d = '0;
    if (is_read) begin
      rsp_d.kind      = dmac_pkg::KIND_READ;
      rsp_d.read_data = rd_hit ? rd_data : s_obus_q;
    end else begin
      rsp_d.kind              = dmac_pkg::KIND_XFER;
      rsp_d.a_address         = a_addr;
      rsp_d.b_register        = b_reg;
      rsp_d.b_to_a            = view.ctl[dmac_pkg::CTL_DIR];
      rsp_d.a_access_allowed  = dmac_pkg::a_ok(a_addr);
      rsp_d.wram_pair_allowed = dmac_pkg::wram_ok(b_reg, a_addr);
      rsp_d.channel           = step_ch;
      rsp_d.channel_done      = done;
    end
  end

  // run flags and pattern position
  always_comb begin
    run_d = run_q;
    pos_d = pos_q;
    if (adv && is_enable) begin
      run_d = s_wdata_q[CH-1:0];
      pos_d = 2'd0;
    end else if (rf_req.step) begin
      if (done) begin
        run_d[step_ch] = 1'b0;
        pos_d          = 2'd0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      pos_q <= 2'd0;
    end else begin
      run_q <= run_d;
      pos_q <= pos_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s_action_q <= req_i.action;
      s_addr_q   <= req_i.address;
      s_wdata_q  <= req_i.write_data;
      s_obus_q   <= req_i.open_bus_value;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.kind              = out_q.kind;
  assign rsp_o.read_data         = out_q.read_data;
  assign rsp_o.a_address         = out_q.a_address;
  assign rsp_o.b_register        = out_q.b_register;
  assign rsp_o.b_to_a            = out_q.b_to_a;
  assign rsp_o.a_access_allowed  = out_q.a_access_allowed;
  assign rsp_o.wram_pair_allowed = out_q.wram_pair_allowed;
  assign rsp_o.channel           = out_q.channel;
  assign rsp_o.channel_done      = out_q.channel_done;

  // checks
  a_enable_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_enable |=> pos_q == 2'd0)
    else $error("pattern position not cleared by enable write");

  a_done_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_req.step && done |=> !run_q[$past(step_ch)])
    else $error("finished channel still running");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_q))
    else $error("pending result beat lost or changed");

  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == dmac_pkg::KIND_READ |->
      out_q.a_address == 24'h0 && out_q.channel == '0 && !out_q.channel_done)
    else $error("read beat carries transfer fields");

endmodule
